// ===== rtl/assert_macros.svh =====
// Assertion macros used by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define HFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also active during reset.
`define HFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFR_ASSERT(lbl, clk, rstn, prop, msg)
`define HFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/hfr_pkg.sv =====
// Types, constants and key tables for the HTTP request framer.
`default_nettype none
package hfr_pkg;

  localparam int LENGTH_WIDTH_DEF = 24;
  localparam int CFG_W            = 24;
  localparam int KEY_LEN          = 15;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 24'd1048576;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_DROP   = 3'b100
  } phase_t;

  // value parser: which key was found and where in the atoi form we are
  typedef enum logic [6:0] {
    VM_NONE    = 7'b0000001,
    VM_LO_LEAD = 7'b0000010,
    VM_LO_DIG  = 7'b0000100,
    VM_LO_DONE = 7'b0001000,
    VM_EX_LEAD = 7'b0010000,
    VM_EX_DIG  = 7'b0100000,
    VM_EX_DONE = 7'b1000000
  } vmode_t;

  function automatic logic [7:0] exact_key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "L";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = "C";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] lower_key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = "c";
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hfr_channels.sv =====
// Valid/ready channel interfaces: input bytes, framed results, configuration.
`default_nettype none
interface hfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_connection;
  modport source (output valid, output data_byte, output new_connection, input ready);
  modport sink   (input valid, input data_byte, input new_connection, output ready);
endinterface

interface hfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_body;
  logic       request_end;
  logic       too_large;
  logic       dropped;
  modport source (output valid, output out_byte, output is_body, output request_end,
                  output too_large, output dropped, input ready);
  modport sink   (input valid, input out_byte, input is_body, input request_end,
                  input too_large, input dropped, output ready);
endinterface

interface hfr_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [hfr_pkg::CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/http_request_framer.sv =====
// HTTP/1.1 request framer: header scan, Content-Length parse, body count.
//
//  channel | dir | payload                                          | transaction
//  --------+-----+--------------------------------------------------+------------------
//  in_if   | in  | data_byte[7:0], new_connection                   | valid & ready
//  out_if  | out | out_byte[7:0], is_body, request_end, too_large,  | valid & ready
//          |     | dropped                                          |
//  cfg_if  | in  | data[23:0] = max_body_length                     | valid & ready
//
// One byte per cycle sustained while out_if.ready is high; each byte passes the input
// register, then the parse step that updates the match/count state and loads the
// result register. The state update of the parse step sets the rate.
// rst_n is synchronous: clears parse state, max_body_length returns to 1048576.
// When out_if.ready is low the result and input registers hold and in_if.ready
// drops once both are full. cfg_if.ready is always high.
`default_nettype none
`include "assert_macros.svh"
module http_request_framer #(
  parameter int LENGTH_WIDTH = hfr_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hfr_in_if.sink     in_if,
  hfr_out_if.source  out_if,
  hfr_cfg_if.sink    cfg_if
);

  localparam int MW = LENGTH_WIDTH + 1;   // magnitude, saturates at 2^LENGTH_WIDTH
  localparam int AW = LENGTH_WIDTH + 5;   // mag*10 + digit
  localparam int CW = (MW > hfr_pkg::CFG_W) ? MW : hfr_pkg::CFG_W;
  localparam logic [AW-1:0] SAT_ACC = AW'(1) << LENGTH_WIDTH;
  localparam logic [MW-1:0] SAT_MAG = MW'(1) << LENGTH_WIDTH;

  typedef struct packed {
    hfr_pkg::phase_t         phase;
    logic [1:0]              term;
    logic [3:0]              ex_prog;
    logic [3:0]              lo_prog;
    hfr_pkg::vmode_t         mode;
    logic                    ex_neg;
    logic                    lo_neg;
    logic [MW-1:0]           ex_mag;
    logic [MW-1:0]           lo_mag;
    logic [LENGTH_WIDTH-1:0] rem;
  } parse_t;

  typedef struct packed {
    logic is_body;
    logic request_end;
    logic too_large;
    logic dropped;
  } flags_t;

  localparam parse_t PARSE_CLR = '{
    phase:   hfr_pkg::PH_HEADER,
    term:    2'd0,
    ex_prog: 4'd0,
    lo_prog: 4'd0,
    mode:    hfr_pkg::VM_NONE,
    ex_neg:  1'b0,
    lo_neg:  1'b0,
    ex_mag:  '0,
    lo_mag:  '0,
    rem:     '0
  };

  function automatic logic [MW-1:0] acc_digit(input logic [MW-1:0] mag,
                                              input logic [7:0] c);
    logic [AW-1:0] ext;
    logic [AW-1:0] m;
    ext = AW'(mag);
    m   = (ext << 3) + (ext << 1) + AW'(c - hfr_pkg::CH_0);
    return (m > SAT_ACC) ? SAT_MAG : m[MW-1:0];
  endfunction

  // key matcher step: returns {hit, next progress}
  function automatic logic [4:0] key_step(input logic [3:0] prog, input logic [7:0] c,
                                          input logic is_exact);
    logic [3:0] p;
    logic [7:0] kc;
    logic [7:0] k0;
    logic [4:0] res;
    p  = (prog >= 4'(hfr_pkg::KEY_LEN)) ? 4'd0 : prog;
    kc = is_exact ? hfr_pkg::exact_key_char(p) : hfr_pkg::lower_key_char(p);
    k0 = is_exact ? hfr_pkg::exact_key_char(4'd0) : hfr_pkg::lower_key_char(4'd0);
    if (c == kc) begin
      if (p == 4'(hfr_pkg::KEY_LEN - 1)) res = {1'b1, 4'd0};
      else                               res = {1'b0, p + 4'd1};
    end else begin
      res = {1'b0, (c == k0) ? 4'd1 : 4'd0};
    end
    return res;
  endfunction

  logic [hfr_pkg::CFG_W-1:0] max_len_r;

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_newc_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  flags_t     out_flags_r;

  parse_t     st_r, st_nxt;
  flags_t     flags_nxt;
  logic       adv;

  assign adv          = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || adv;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.is_body     = out_flags_r.is_body;
  assign out_if.request_end = out_flags_r.request_end;
  assign out_if.too_large   = out_flags_r.too_large;
  assign out_if.dropped     = out_flags_r.dropped;

  // parse step
  always_comb begin
    parse_t                  cur;
    logic [7:0]              c;
    logic                    digit;
    logic                    lead;
    logic                    side_ex;
    logic [4:0]              ex_k;
    logic [4:0]              lo_k;
    logic                    ended;
    logic                    sel_neg;
    logic [MW-1:0]           sel_mag;
    logic [LENGTH_WIDTH-1:0] rem_dec;

    c         = s1_data_r;
    cur       = s1_newc_r ? PARSE_CLR : st_r;
    st_nxt    = cur;
    flags_nxt = '0;
    digit     = (c >= hfr_pkg::CH_0) && (c <= hfr_pkg::CH_9);
    lead      = (cur.mode == hfr_pkg::VM_LO_LEAD) || (cur.mode == hfr_pkg::VM_EX_LEAD);
    side_ex   = (cur.mode == hfr_pkg::VM_EX_LEAD) || (cur.mode == hfr_pkg::VM_EX_DIG);
    ex_k      = '0;
    lo_k      = '0;
    ended     = 1'b0;
    sel_neg   = 1'b0;
    sel_mag   = '0;
    rem_dec   = cur.rem - ((cur.rem != '0) ? LENGTH_WIDTH'(1) : '0);

    case (cur.phase)
      hfr_pkg::PH_DROP: begin
        flags_nxt.dropped = 1'b1;
      end
      hfr_pkg::PH_BODY: begin
        flags_nxt.is_body = 1'b1;
        st_nxt.rem        = rem_dec;
        if (rem_dec == '0) begin
          flags_nxt.request_end = 1'b1;
          st_nxt                = PARSE_CLR;
        end
      end
      default: begin
        // value parser, active in the leading and digit stages of either key
        if (lead || cur.mode == hfr_pkg::VM_LO_DIG || cur.mode == hfr_pkg::VM_EX_DIG) begin
          if (digit) begin
            if (side_ex) st_nxt.ex_mag = acc_digit(cur.ex_mag, c);
            else         st_nxt.lo_mag = acc_digit(cur.lo_mag, c);
            st_nxt.mode = side_ex ? hfr_pkg::VM_EX_DIG : hfr_pkg::VM_LO_DIG;
          end else if (lead && hfr_pkg::is_ws(c)) begin
            st_nxt.mode = cur.mode;
          end else if (lead && c == hfr_pkg::CH_PLUS) begin
            st_nxt.mode = side_ex ? hfr_pkg::VM_EX_DIG : hfr_pkg::VM_LO_DIG;
          end else if (lead && c == hfr_pkg::CH_MINUS) begin
            if (side_ex) st_nxt.ex_neg = 1'b1;
            else         st_nxt.lo_neg = 1'b1;
            st_nxt.mode = side_ex ? hfr_pkg::VM_EX_DIG : hfr_pkg::VM_LO_DIG;
          end else begin
            st_nxt.mode = side_ex ? hfr_pkg::VM_EX_DONE : hfr_pkg::VM_LO_DONE;
          end
        end

        ex_k           = key_step(cur.ex_prog, c, 1'b1);
        lo_k           = key_step(cur.lo_prog, c, 1'b0);
        st_nxt.ex_prog = ex_k[3:0];
        st_nxt.lo_prog = lo_k[3:0];
        // exact-case key overrides a lower-case one found earlier
        if (ex_k[4] && !(st_nxt.mode == hfr_pkg::VM_EX_LEAD ||
                         st_nxt.mode == hfr_pkg::VM_EX_DIG ||
                         st_nxt.mode == hfr_pkg::VM_EX_DONE)) begin
          st_nxt.mode   = hfr_pkg::VM_EX_LEAD;
          st_nxt.ex_neg = 1'b0;
          st_nxt.ex_mag = '0;
        end else if (lo_k[4] && st_nxt.mode == hfr_pkg::VM_NONE) begin
          st_nxt.mode   = hfr_pkg::VM_LO_LEAD;
          st_nxt.lo_neg = 1'b0;
          st_nxt.lo_mag = '0;
        end

        // CRLFCRLF tracking
        if (c == hfr_pkg::CH_CR) begin
          st_nxt.term = (cur.term == 2'd2) ? 2'd3 : 2'd1;
        end else if (c == hfr_pkg::CH_LF && (cur.term == 2'd1 || cur.term == 2'd3)) begin
          ended       = (cur.term == 2'd3);
          st_nxt.term = ended ? 2'd0 : 2'd2;
        end else begin
          st_nxt.term = 2'd0;
        end

        if (ended) begin
          if (st_nxt.mode == hfr_pkg::VM_EX_LEAD || st_nxt.mode == hfr_pkg::VM_EX_DIG ||
              st_nxt.mode == hfr_pkg::VM_EX_DONE) begin
            sel_neg = st_nxt.ex_neg;
            sel_mag = st_nxt.ex_mag;
          end else if (st_nxt.mode != hfr_pkg::VM_NONE) begin
            sel_neg = st_nxt.lo_neg;
            sel_mag = st_nxt.lo_mag;
          end
          st_nxt = PARSE_CLR;
          if ((sel_neg && sel_mag != '0) || sel_mag[LENGTH_WIDTH] ||
              (CW'(sel_mag) > CW'(max_len_r))) begin
            flags_nxt.too_large = 1'b1;
            st_nxt.phase        = hfr_pkg::PH_DROP;
          end else if (sel_mag == '0) begin
            flags_nxt.request_end = 1'b1;
          end else begin
            st_nxt.phase = hfr_pkg::PH_BODY;
            st_nxt.rem   = sel_mag[LENGTH_WIDTH-1:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= hfr_pkg::MAX_LEN_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= PARSE_CLR;
    end else begin
      if (cfg_if.valid) begin
        max_len_r <= cfg_if.data;
      end
      if (in_if.valid && in_if.ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_data_r <= in_if.data_byte;
      s1_newc_r <= in_if.new_connection;
    end
    if (adv) begin
      out_byte_r  <= s1_data_r;
      out_flags_r <= flags_nxt;
    end
  end

  `HFR_ASSERT(a_body_rem_nonzero, clk, rst_n, (st_r.phase == hfr_pkg::PH_BODY) |-> (st_r.rem != '0), "body phase with zero bytes remaining")
  `HFR_ASSERT(a_reject_to_drop, clk, rst_n, (adv && flags_nxt.too_large) |=> (st_r.phase == hfr_pkg::PH_DROP), "rejected request did not enter drop phase")
  `HFR_ASSERT(a_flags_exclusive, clk, rst_n, (out_valid_r && out_flags_r.too_large) |-> (!out_flags_r.is_body && !out_flags_r.dropped && !out_flags_r.request_end), "too_large set together with another flag")
  `HFR_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid_r && !s1_valid_r && st_r.phase == hfr_pkg::PH_HEADER), "reset did not clear the pipeline")

endmodule
`default_nettype wire
